// ===== src/mpia_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the multi-pool id allocator.
// No dependencies; used by the top level.
package mpia_pkg;

	localparam int NUM_W    = 16;
	localparam int POOL_W   = 5;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;

	typedef enum logic [OP_W-1:0] {
		OP_GET     = 2'd0,
		OP_RECYCLE = 2'd1,
		OP_RESET   = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FRESH     = 3'd0,
		ST_REUSED    = 3'd1,
		ST_RECYCLED  = 3'd2,
		ST_EXHAUSTED = 3'd3,
		ST_FULL      = 3'd4,
		ST_RESET     = 3'd5
	} status_t;

endpackage

// ===== src/multi_pool_id_allocator_unit.sv =====
`timescale 1ns / 1ps
// Multi-pool identifier allocator: top level.
// Depends on mpia_pkg and mpia_ram.

// Each request beat names a pool and an operation. A get returns the oldest
// recycled number of that pool, or else the pool's fresh counter (1 upward,
// stopping with status exhausted at the all-ones value instead of wrapping).
// A recycle appends a number to the pool's FIFO free list of FREE_DEPTH
// entries, or drops it with status full. A pool reset empties the list and
// restarts the counter at 1. Requests to a pool index at or above NUM_POOLS
// and the unused operation code change nothing. Every request gives exactly
// one result beat. The block takes one request per cycle while in_stall is
// low: the request is registered, the addressed pool's counter and ring
// pointers go through one read-modify-write in that stage, and the result
// lands in the output register while the free-list RAM read completes on
// the same edge. Pool state lives in flip-flops that reset clears at once;
// the free-list RAM needs no clearing, since the fill count guards every
// read.
module multi_pool_id_allocator_unit #(
	parameter int NUM_POOLS  = 17,
	parameter int ID_WIDTH   = 16,
	parameter int FREE_DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mpia_pkg::OP_W-1:0]       operation,
	input  logic [mpia_pkg::POOL_W-1:0]     pool,
	input  logic [mpia_pkg::NUM_W-1:0]      number,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mpia_pkg::NUM_W-1:0]      number_out,
	output logic [mpia_pkg::STATUS_W-1:0]   status
);

	localparam int PIDX_W = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
	localparam int PTR_W  = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(FREE_DEPTH + 1);
	localparam int RAM_DEPTH = NUM_POOLS * FREE_DEPTH;
	localparam int ADDR_W = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

	localparam logic [ID_WIDTH-1:0] ID_TOP   = {ID_WIDTH{1'b1}};
	localparam logic [ID_WIDTH-1:0] ID_FIRST = ID_WIDTH'(1);
	localparam logic [CNT_W-1:0]    CNT_FULL = CNT_W'(FREE_DEPTH);
	localparam logic [PTR_W-1:0]    PTR_LAST = PTR_W'(FREE_DEPTH - 1);
	localparam logic [ADDR_W-1:0]   POOL_STRIDE = ADDR_W'(FREE_DEPTH);

	// Per-pool state
	logic [ID_WIDTH-1:0] fresh_q [NUM_POOLS];
	logic [PTR_W-1:0]    head_q  [NUM_POOLS];
	logic [PTR_W-1:0]    tail_q  [NUM_POOLS];
	logic [CNT_W-1:0]    count_q [NUM_POOLS];

	// Request stage
	logic                        valid_s1;
	logic [mpia_pkg::OP_W-1:0]   op_s1;
	logic [mpia_pkg::POOL_W-1:0] pool_s1;
	logic [ID_WIDTH-1:0]         num_s1;

	// Result stage
	logic                  valid_s2;
	logic                  reuse_s2;
	logic [ID_WIDTH-1:0]   num_s2;
	mpia_pkg::status_t     status_s2;

	logic adv;
	logic fire;
	logic ld_s1;

	// Pipeline moves whenever the result register is free or drained this cycle.
	assign adv      = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && adv;
	// Load the request register when it is empty or its beat moves on.
	assign ld_s1    = adv || !valid_s1;
	assign in_stall = !ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ld_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && in_valid) begin
			op_s1   <= operation;
			pool_s1 <= pool;
			num_s1  <= ID_WIDTH'(number);
		end
	end

	// Read the addressed pool's state and work out the update.
	logic [PIDX_W-1:0]   pidx;
	logic                pool_ok;
	logic [ID_WIDTH-1:0] cur_fresh;
	logic [PTR_W-1:0]    cur_head;
	logic [PTR_W-1:0]    cur_tail;
	logic [CNT_W-1:0]    cur_cnt;
	logic [ADDR_W-1:0]   pool_base;

	assign pidx      = PIDX_W'(pool_s1);
	assign pool_ok   = int'(pool_s1) < NUM_POOLS;
	assign cur_fresh = fresh_q[pidx];
	assign cur_head  = head_q[pidx];
	assign cur_tail  = tail_q[pidx];
	assign cur_cnt   = count_q[pidx];
	assign pool_base = ADDR_W'(pidx) * POOL_STRIDE;

	logic [ID_WIDTH-1:0] nxt_fresh;
	logic [PTR_W-1:0]    nxt_head;
	logic [PTR_W-1:0]    nxt_tail;
	logic [CNT_W-1:0]    nxt_cnt;
	logic                upd_state;
	logic                res_reuse;
	logic [ID_WIDTH-1:0] res_num;
	mpia_pkg::status_t   res_st;
	logic                ram_we;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [ID_WIDTH-1:0] ram_rdata;

	always_comb begin
		nxt_fresh = cur_fresh;
		nxt_head  = cur_head;
		nxt_tail  = cur_tail;
		nxt_cnt   = cur_cnt;
		upd_state = 1'b0;
		res_reuse = 1'b0;
		res_num   = '0;
		res_st    = mpia_pkg::ST_EXHAUSTED;
		case (op_s1)
			mpia_pkg::OP_GET: begin
				if (pool_ok && cur_cnt != '0) begin
					// Pop the oldest recycled number; its value comes from RAM.
					nxt_head  = (cur_head == PTR_LAST) ? '0 : cur_head + PTR_W'(1);
					nxt_cnt   = cur_cnt - CNT_W'(1);
					upd_state = 1'b1;
					res_reuse = 1'b1;
					res_st    = mpia_pkg::ST_REUSED;
				end else if (pool_ok && cur_fresh != ID_TOP) begin
					nxt_fresh = cur_fresh + ID_WIDTH'(1);
					upd_state = 1'b1;
					res_num   = cur_fresh;
					res_st    = mpia_pkg::ST_FRESH;
				end
			end
			mpia_pkg::OP_RECYCLE: begin
				if (pool_ok && cur_cnt < CNT_FULL) begin
					nxt_tail  = (cur_tail == PTR_LAST) ? '0 : cur_tail + PTR_W'(1);
					nxt_cnt   = cur_cnt + CNT_W'(1);
					upd_state = 1'b1;
					res_st    = mpia_pkg::ST_RECYCLED;
				end else begin
					res_st = mpia_pkg::ST_FULL;
				end
			end
			mpia_pkg::OP_RESET: begin
				if (pool_ok) begin
					nxt_fresh = ID_FIRST;
					nxt_head  = '0;
					nxt_tail  = '0;
					nxt_cnt   = '0;
					upd_state = 1'b1;
				end
				res_st = mpia_pkg::ST_RESET;
			end
			default: begin
				res_st = mpia_pkg::ST_EXHAUSTED;
			end
		endcase
	end

	// Write back the pool state on the edge that hands the beat on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_POOLS; p++) begin
				fresh_q[p] <= ID_FIRST;
				head_q[p]  <= '0;
				tail_q[p]  <= '0;
				count_q[p] <= '0;
			end
		end else if (fire && upd_state) begin
			fresh_q[pidx] <= nxt_fresh;
			head_q[pidx]  <= nxt_head;
			tail_q[pidx]  <= nxt_tail;
			count_q[pidx] <= nxt_cnt;
		end
	end

	// Free-list ring: a recycle writes at the tail, a reuse reads at the head.
	// The read data register holds while the result waits downstream.
	assign ram_we    = fire && (op_s1 == mpia_pkg::OP_RECYCLE) && upd_state;
	assign ram_re    = fire && res_reuse;
	assign ram_waddr = pool_base + ADDR_W'(cur_tail);
	assign ram_raddr = pool_base + ADDR_W'(cur_head);

	mpia_ram #(
		.WIDTH(ID_WIDTH),
		.DEPTH(RAM_DEPTH)
	) u_free_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(num_s1),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			reuse_s2  <= res_reuse;
			num_s2    <= res_num;
			status_s2 <= res_st;
		end
	end

	assign out_valid  = valid_s2;
	assign number_out = reuse_s2 ? mpia_pkg::NUM_W'(ram_rdata) : mpia_pkg::NUM_W'(num_s2);
	assign status     = status_s2;

	// The fill count of a live pool never passes the ring depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && pool_ok |-> cur_cnt <= CNT_FULL)
		else $error("free-list count above depth");

	// A fresh number is never zero.
	a_fresh_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status_s2 == mpia_pkg::ST_FRESH |-> number_out != '0)
		else $error("fresh number is zero");

	// Only gets return a number.
	a_num_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status_s2 != mpia_pkg::ST_FRESH && status_s2 != mpia_pkg::ST_REUSED
		|-> number_out == '0)
		else $error("nonzero number on a non-get result");

	// A reuse result came through a RAM read on the edge that loaded it.
	a_reuse_read: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_reuse |=> valid_s2 && reuse_s2 && status_s2 == mpia_pkg::ST_REUSED)
		else $error("reuse result lost its RAM read");

	// The RAM never sees a write and a read in one cycle.
	a_ram_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("free-list RAM read and write together");

endmodule

// ===== src/mpia_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mpia_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 272,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
